### rtl/core/ffs_pkg.sv
package ffs_pkg;

    // entry store depth and the index width that follows from it
    localparam int PIXELS = 65536;
    localparam int ADDR_W = $clog2(PIXELS);

    // field widths
    localparam int ADDR_IN_W = 16;
    localparam int PLANE_W   = 8;
    localparam int MEAS_W    = 32;
    localparam int COEF_W    = 24;
    localparam int MAP_W     = 8;
    localparam int SUM_W     = 32;

    // address reduction by reciprocal multiply, then one multiply-subtract and one correction
    localparam int RECIP_W     = 33;
    localparam int RECIP_SHIFT = 32;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(PIXELS));
    localparam int PROD_W = ADDR_IN_W + RECIP_W;
    localparam int QUOT_W = ADDR_IN_W;
    localparam int WIDE_W = ADDR_IN_W + ADDR_W + 2;

    localparam logic [MAP_W-1:0] MAP_INIT = MAP_W'(1);
    localparam logic [MAP_W-1:0] MAP_MAX  = {MAP_W{1'b1}};

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef logic [ADDR_W-1:0] ffs_idx_t;
    typedef logic [QUOT_W-1:0] ffs_quot_t;
    typedef logic [WIDE_W-1:0] ffs_wide_t;

    typedef struct packed {
        logic [ADDR_IN_W-1:0]     pixel_address;
        logic [PLANE_W-1:0]       plane_number;
        logic                     first_plane;
        logic [MEAS_W-1:0]        high_measure;
        logic [MEAS_W-1:0]        low_measure;
        logic signed [COEF_W-1:0] approx_coef;
        logic signed [COEF_W-1:0] horiz_coef;
        logic signed [COEF_W-1:0] vert_coef;
        logic signed [COEF_W-1:0] diag_coef;
    } ffs_in_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] fused_approx;
        logic signed [COEF_W-1:0] fused_horiz;
        logic signed [COEF_W-1:0] fused_vert;
        logic signed [COEF_W-1:0] fused_diag;
        logic [MAP_W-1:0]         high_plane_map;
        logic [MAP_W-1:0]         low_plane_map;
        logic signed [SUM_W-1:0]  approx_sum;
        logic [MEAS_W-1:0]        best_high;
        logic [MEAS_W-1:0]        best_low;
    } ffs_out_t;

    typedef struct packed {
        logic     rd_en;
        ffs_idx_t rd_idx;
        logic     wr_en;
        ffs_idx_t wr_idx;
    } ffs_mem_ctrl_t;

    // floor(addr / PIXELS), possibly one low
    function automatic ffs_quot_t addr_quotient(input logic [ADDR_IN_W-1:0] addr);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(addr) * PROD_W'(RECIP);
        return prod[RECIP_SHIFT +: QUOT_W];
    endfunction

    // addr - quot * PIXELS with one correction step
    function automatic ffs_wide_t addr_remainder(input logic [ADDR_IN_W-1:0] addr,
                                                 input ffs_quot_t quot);
        ffs_wide_t qp;
        ffs_wide_t rem;
        qp  = WIDE_W'(quot) * WIDE_W'(PIXELS);
        rem = WIDE_W'(addr) - qp;
        if (rem >= WIDE_W'(PIXELS))
        begin
            rem = rem - WIDE_W'(PIXELS);
        end
        return rem;
    endfunction

endpackage

### rtl/core/ffs_update.sv
module ffs_update (
    input  ffs_pkg::ffs_in_t  item,
    input  ffs_pkg::ffs_out_t entry,
    output ffs_pkg::ffs_out_t updated
);

    logic [ffs_pkg::MAP_W-1:0]        map_val;
    logic signed [ffs_pkg::SUM_W:0]   sum_wide;
    logic signed [ffs_pkg::SUM_W-1:0] sum_sat;
    logic signed [ffs_pkg::SUM_W-1:0] coef_ext;

    assign coef_ext = {{(ffs_pkg::SUM_W-ffs_pkg::COEF_W){item.approx_coef[ffs_pkg::COEF_W-1]}},
                       item.approx_coef};

    // plane + 1, held at the top code
    assign map_val = (item.plane_number == ffs_pkg::MAP_MAX) ? ffs_pkg::MAP_MAX
                                                            : item.plane_number + 1'b1;

    always_comb
    begin
        sum_wide = {entry.approx_sum[ffs_pkg::SUM_W-1], entry.approx_sum}
                 + {coef_ext[ffs_pkg::SUM_W-1], coef_ext};
        if (sum_wide[ffs_pkg::SUM_W] != sum_wide[ffs_pkg::SUM_W-1])
        begin
            sum_sat = sum_wide[ffs_pkg::SUM_W] ? ffs_pkg::SUM_MIN : ffs_pkg::SUM_MAX;
        end
        else
        begin
            sum_sat = sum_wide[ffs_pkg::SUM_W-1:0];
        end
    end

    always_comb
    begin
        updated = entry;
        if (item.first_plane)
        begin
            updated.fused_approx   = item.approx_coef;
            updated.fused_horiz    = item.horiz_coef;
            updated.fused_vert     = item.vert_coef;
            updated.fused_diag     = item.diag_coef;
            updated.high_plane_map = ffs_pkg::MAP_INIT;
            updated.low_plane_map  = ffs_pkg::MAP_INIT;
            updated.approx_sum     = coef_ext;
            updated.best_high      = item.high_measure;
            updated.best_low       = item.low_measure;
        end
        else
        begin
            // detail bands follow the detail measure
            if (item.high_measure > entry.best_high)
            begin
                updated.best_high      = item.high_measure;
                updated.fused_horiz    = item.horiz_coef;
                updated.fused_vert     = item.vert_coef;
                updated.fused_diag     = item.diag_coef;
                updated.high_plane_map = map_val;
            end
            if (item.low_measure > entry.best_low)
            begin
                updated.best_low      = item.low_measure;
                updated.fused_approx  = item.approx_coef;
                updated.low_plane_map = map_val;
            end
            updated.approx_sum = sum_sat;
        end
    end

endmodule

### rtl/core/ffs_entry_mem.sv
module ffs_entry_mem (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ffs_pkg::ffs_mem_ctrl_t ctrl,
    input  ffs_pkg::ffs_out_t      wr_data,
    output ffs_pkg::ffs_out_t      rd_entry
);

    ffs_pkg::ffs_out_t mem_array [ffs_pkg::PIXELS];
    ffs_pkg::ffs_out_t rd_data_reg;
    ffs_pkg::ffs_out_t byp_data_reg;
    logic              byp_reg;
    logic              byp_next;

    // a write landing on the address being read goes straight to the reader
    assign byp_next = ctrl.wr_en && (ctrl.wr_idx == ctrl.rd_idx);

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem_array[ctrl.wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            rd_data_reg  <= mem_array[ctrl.rd_idx];
            byp_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= 1'b0;
        end
        else if (ctrl.rd_en)
        begin
            byp_reg <= byp_next;
        end
    end

    assign rd_entry = byp_reg ? byp_data_reg : rd_data_reg;

endmodule

### rtl/core/focus_fusion_selector.sv
// per-pixel multi-focus fusion selector
// pixel channel: one wavelet-domain pixel of one focal plane per item, with
// its entry address, plane number, first-plane flag, two focus measures and
// four subband coefficients
// fused channel: one item per input item, the updated entry for that address,
// in input order
// pipeline: address reduction register, entry store read, then the fusion
// rule between the read data and the result register, which also writes the
// entry back
// throughput: one item per cycle while fused_ready is high; back-to-back items on
// the same address are forwarded from the write-back, so no bubble is needed
// the entry store has no clearing pass: a later plane must follow a first
// plane item for the same address
// reset clears the valid flags of every stage; the store keeps its contents
// when fused_ready is low the result register holds and the stages behind it
// fill up, then pixel_ready drops until the result is taken
module focus_fusion_selector (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pixel_valid,
    output logic              pixel_ready,
    input  ffs_pkg::ffs_in_t  pixel,
    output logic              fused_valid,
    input  logic              fused_ready,
    output ffs_pkg::ffs_out_t fused
);

    // stage 0: input register plus quotient of the address
    logic               s0_valid_reg;
    ffs_pkg::ffs_in_t   s0_item_reg;
    ffs_pkg::ffs_quot_t s0_quot_reg;

    // stage 1: item with its store index, read data arrives here
    logic               s1_valid_reg;
    ffs_pkg::ffs_in_t   s1_item_reg;
    ffs_pkg::ffs_idx_t  s1_idx_reg;

    // result register
    logic               out_valid_reg;
    logic               out_valid_next;
    ffs_pkg::ffs_out_t  out_data_reg;

    logic               out_free;
    logic               s1_adv;
    logic               s1_open;
    logic               s0_adv;
    logic               s0_open;
    logic               pixel_take;

    ffs_pkg::ffs_wide_t     s0_rem;
    ffs_pkg::ffs_idx_t      s0_idx;
    ffs_pkg::ffs_mem_ctrl_t mem_ctrl;
    ffs_pkg::ffs_out_t      old_entry;
    ffs_pkg::ffs_out_t      new_entry;

    // stall chain from the output back to the input
    assign out_free   = !out_valid_reg || fused_ready;
    assign s1_adv     = s1_valid_reg && out_free;
    assign s1_open    = !s1_valid_reg || s1_adv;
    assign s0_adv     = s0_valid_reg && s1_open;
    assign s0_open    = !s0_valid_reg || s0_adv;
    assign pixel_take = pixel_valid && s0_open;

    assign pixel_ready = s0_open;

    // address modulo entry count, second half of the reduction
    assign s0_rem = ffs_pkg::addr_remainder(s0_item_reg.pixel_address, s0_quot_reg);
    assign s0_idx = s0_rem[ffs_pkg::ADDR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (s0_open)
        begin
            s0_valid_reg <= pixel_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pixel_take)
        begin
            s0_item_reg <= pixel;
            s0_quot_reg <= ffs_pkg::addr_quotient(pixel.pixel_address);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_open)
        begin
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_adv)
        begin
            s1_item_reg <= s0_item_reg;
            s1_idx_reg  <= s0_idx;
        end
    end

    // read when an item moves into stage 1, write back when it leaves
    always_comb
    begin
        mem_ctrl.rd_en  = s0_adv;
        mem_ctrl.rd_idx = s0_idx;
        mem_ctrl.wr_en  = s1_adv;
        mem_ctrl.wr_idx = s1_idx_reg;
    end

    ffs_entry_mem u_entry_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (mem_ctrl),
        .wr_data  (new_entry),
        .rd_entry (old_entry)
    );

    ffs_update u_update (
        .item    (s1_item_reg),
        .entry   (old_entry),
        .updated (new_entry)
    );

    always_comb
    begin
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (fused_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_data_reg <= new_entry;
        end
    end

    assign fused_valid = out_valid_reg;
    assign fused       = out_data_reg;

`ifndef SYNTHESIS
    // an accepted item is always captured in stage 0
    a_take_lands: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_take |=> s0_valid_reg)
        else $error("accepted item not held in stage 0");

    // a blocked stage 1 item keeps its index so the write-back goes to the read entry
    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_idx_reg)))
        else $error("stage 1 item lost or moved while stalled");

    // every item leaving stage 1 produces a result
    a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid_reg)
        else $error("stage 1 item did not reach the result register");

    // reduced address stays inside the store
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        s0_valid_reg |-> (s0_rem < ffs_pkg::WIDE_W'(ffs_pkg::PIXELS)))
        else $error("entry index out of range");
`endif

endmodule
